[rtl/tdma_slot_timing_scheduler_macros.svh]
// Assertion macros shared by the scheduler modules.
`ifndef TDMA_SLOT_TIMING_SCHEDULER_MACROS_SVH
`define TDMA_SLOT_TIMING_SCHEDULER_MACROS_SVH
`ifndef SYNTHESIS
`define TSTS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define TSTS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define TSTS_ASSERT(label, clk, rst, prop, msg)
`define TSTS_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

[rtl/tsts_pkg.sv]
// Types and constants of the TDMA slot timing scheduler.
package tsts_pkg;
   localparam logic [1:0] MODE_TICK  = 2'd0;
   localparam logic [1:0] MODE_SETT  = 2'd1;
   localparam logic [1:0] MODE_ALLOC = 2'd2;
   localparam logic [2:0] REG_BURST  = 3'd0;
   localparam logic [2:0] REG_SPER   = 3'd1;
   localparam logic [2:0] REG_SLEN   = 3'd2;
   localparam logic [2:0] REG_FLAT   = 3'd3;
   localparam logic [2:0] REG_SSAMP  = 3'd4;
   localparam logic [11:0] TICK_MAX  = 12'd4095;
   localparam logic [19:0] NS_PER_MS = 20'd1000000;
   // result item
   typedef struct packed {
      logic       queue_overflow;
      logic       initialized;
      logic       lead_valid;
      logic [62:0] lead_time;
      logic [62:0] slot_start;
      logic [7:0] fired_slot;
   } result_type;
endpackage

[rtl/tsts_ram.sv]
// Generic single-port-write, single-read RAM with registered read data.
module tsts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

[rtl/tdma_slot_timing_scheduler.sv]
// Top level of the TDMA slot timing scheduler.
//
// Channels: req_ (tuser: mode; tdata: channel, base_received, time_value,
// slot_number), rsp_ (tdata: fired_slot, slot_start, lead_time, lead_valid,
// initialized, queue_overflow), and csr_ (index/data write of five registers).
// Every input item yields exactly one result item.
// Each item runs through a short sequencer: read the channel state word, then
// the queue head entry it points to, form the two products through one shared
// 32x32 multiplier, then compare and write back. The next item is taken only
// once the sequencer is back in idle after loading the result, so the sequencer
// works on one item at a time.
// While the receiver stalls, the result holds in the output register; the next
// item is taken and runs up to its evaluation step, then waits there until the
// output register frees up, which holds the input off.
// Reset clears the channel state memory with a clearing pass over all 2**CW
// entries (four with four channels); no item is accepted during it.
// Configuration writes are taken at all times but belong between items.
// Queue entries need no clearing: they are read only after being written.
module tdma_slot_timing_scheduler #(
   parameter int CHANNELS    = 4,
   parameter int QUEUE_DEPTH = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // [1:0] mode
   input  logic [1:0]   req_tuser,
   // [1:0] channel, [2] base_received, [65:3] time_value,
   // [73:66] slot_number, [79:74] zero
   input  logic [79:0]  req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [7:0] fired_slot, [70:8] slot_start, [133:71] lead_time,
   // [134] lead_valid, [135] initialized, [136] queue_overflow, [143:137] zero
   output logic [143:0] rsp_tdata,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [29:0]  csr_data
);
`include "tdma_slot_timing_scheduler_macros.svh"
   localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int QW = $clog2(QUEUE_DEPTH);
   localparam int FW = QW + 1;
   localparam int SW = 32 + 64 + 64 + 1 + QW + FW;   // channel state word
   localparam int EW = 8 + 64 + 12;                   // queue entry word

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_READ, ST_MUL_LO, ST_MUL_HI, ST_NOW, ST_FL_LO,
      ST_FL_HI, ST_EVAL, ST_WRITE, ST_OUT
   } state_type;

   // configuration registers
   logic [9:0]  burst_ff;
   logic [19:0] sper_ff;
   logic [29:0] slen_ff;
   logic [9:0]  flat_ff;
   logic [12:0] ssamp_ff;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         burst_ff <= '0; sper_ff <= 20'd41667; slen_ff <= 30'd30000000;
         flat_ff <= '0; ssamp_ff <= 13'd720;
      end else if (csr_valid) begin
         unique case (csr_index)
            tsts_pkg::REG_BURST: burst_ff <= csr_data[9:0];
            tsts_pkg::REG_SPER:  sper_ff  <= csr_data[19:0];
            tsts_pkg::REG_SLEN:  slen_ff  <= csr_data;
            tsts_pkg::REG_FLAT:  flat_ff  <= csr_data[9:0];
            tsts_pkg::REG_SSAMP: ssamp_ff <= csr_data[12:0];
            default: ;
         endcase
      end
   end

   state_type   state_ff;
   logic [1:0]  mode_ff;
   logic [1:0]  chan_ff;
   logic        hold_ff;
   logic [62:0] tval_ff;
   logic [7:0]  snum_ff;
   logic [CW-1:0] clr_ff;
   logic        drop_ff;    // channel out of range

   // unpacked channel state (read-modify copy)
   logic [31:0] cnt_ff;
   logic [63:0] tb_ff;
   logic [63:0] last_ff;
   logic        rdy_ff;
   logic [QW-1:0] head_ff;
   logic [FW-1:0] fill_ff;
   logic [7:0]  qnum_ff;
   logic [63:0] qtime_ff;
   logic [11:0] qtick_ff;
   logic [63:0] prod_ff;    // sample_count * period
   logic [63:0] now_ff;
   logic [63:0] flp_ff;     // 4 * latency * period
   tsts_pkg::result_type res_ff;
   tsts_pkg::result_type res_in;
   logic        rsp_valid_ff;

   logic [SW-1:0] st_rd;
   logic [SW-1:0] st_wr;
   logic          st_we;
   logic [CW-1:0] st_waddr;
   logic [EW-1:0] q_rd;
   logic          q_we;
   logic [CW+QW-1:0] q_waddr;
   logic [EW-1:0] q_wr;
   logic [CW+QW-1:0] q_raddr;

   logic [CW-1:0] chan_idx;
   assign chan_idx = CW'(chan_ff);

   tsts_ram #(.WIDTH(SW), .DEPTH(2**CW)) u_state (
      .clock(clock), .wr_en(st_we), .wr_addr(st_waddr), .wr_data(st_wr),
      .rd_addr(chan_idx), .rd_data(st_rd));

   tsts_ram #(.WIDTH(EW), .DEPTH(2**(CW+QW))) u_queue (
      .clock(clock), .wr_en(q_we), .wr_addr(q_waddr), .wr_data(q_wr),
      .rd_addr(q_raddr), .rd_data(q_rd));

   // queue head address follows the state word as it arrives
   assign q_raddr = {chan_idx, st_rd[QW+FW-1:FW]};

   // one shared multiplier: 32 x 32
   logic [31:0] ma, mb;
   logic [63:0] mp;
   always_comb begin
      ma = 32'd0; mb = 32'd0;
      unique case (state_ff)
         ST_MUL_HI: begin ma = cnt_ff; mb = {12'd0, sper_ff}; end
         ST_FL_LO:  begin ma = {20'd0, flat_ff, 2'b00}; mb = {12'd0, sper_ff}; end
         default: ;
      endcase
      mp = ma * mb;
   end

   // evaluation (registered inputs only)
   logic [63:0] st_time, el_m_last, new_last, start_t, burst_ns, lead_t;
   logic [29:0] burst_mul;
   logic [11:0] thr;
   logic        due, first_fire, retire, ovf, lvalid, new_rdy;
   logic [63:0] four_slen;
   always_comb begin
      four_slen = {32'd0, slen_ff, 2'b00};
      st_time = now_ff - flp_ff;
      due = (fill_ff != '0) && ($signed(st_time) >= $signed(qtime_ff));
      first_fire = due && (qtick_ff == 12'd0);
      thr = (ssamp_ff == 13'd0) ? 12'd0 :
            ((ssamp_ff - 13'd1) > {1'b0, tsts_pkg::TICK_MAX}) ? tsts_pkg::TICK_MAX :
            12'(ssamp_ff - 13'd1);
      retire = due && !first_fire && (qtick_ff >= thr);
      el_m_last = now_ff - last_ff;
      lvalid = 1'b0;
      lead_t = last_ff - now_ff;
      if ($signed(last_ff) >= $signed(now_ff)) begin
         lvalid = (chan_ff == 2'd0);
         new_last = last_ff + {34'd0, slen_ff};
      end else if (last_ff == 64'd0) begin
         new_last = now_ff;
      end else if ($signed(el_m_last) >= $signed({34'd0, slen_ff})) begin
         new_last = now_ff;
      end else begin
         new_last = last_ff + {34'd0, slen_ff};
      end
      burst_mul = {20'd0, burst_ff} * {10'd0, tsts_pkg::NS_PER_MS};
      burst_ns = {34'd0, burst_mul};
      start_t = new_last + burst_ns;
      ovf = (fill_ff >= FW'(QUEUE_DEPTH));
      new_rdy = rdy_ff ||
                ($signed({1'b0, tval_ff}) >= $signed(four_slen + 64'd1));
   end

   // result of the item under evaluation
   always_comb begin
      res_in = '0;
      if (!drop_ff) begin
         res_in.initialized = (mode_ff == tsts_pkg::MODE_SETT) ? new_rdy : rdy_ff;
         if (mode_ff == tsts_pkg::MODE_TICK)
            res_in.fired_slot = first_fire ? qnum_ff : 8'd0;
         if (mode_ff == tsts_pkg::MODE_ALLOC) begin
            res_in.slot_start = start_t[62:0];
            res_in.lead_time = lvalid ? lead_t[62:0] : 63'd0;
            res_in.lead_valid = lvalid;
            res_in.queue_overflow = ovf;
         end
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, res_ff};

   // ring pointers wrap at the queue depth
   logic [QW-1:0] tail, head_nxt;
   logic [FW-1:0] tail_sum;
   assign tail_sum = {1'b0, head_ff} + fill_ff;
   assign tail = (tail_sum >= FW'(QUEUE_DEPTH)) ? QW'(tail_sum - FW'(QUEUE_DEPTH)) :
                 QW'(tail_sum);
   assign head_nxt = (head_ff == QW'(QUEUE_DEPTH - 1)) ? '0 : QW'(head_ff + QW'(1));

   always_comb begin
      st_we = 1'b0; st_waddr = chan_idx; st_wr = '0;
      q_we = 1'b0; q_waddr = {chan_idx, head_ff}; q_wr = '0;
      if (state_ff == ST_CLEAR) begin
         st_we = 1'b1; st_waddr = clr_ff;
      end else if (state_ff == ST_WRITE && !drop_ff) begin
         st_we = 1'b1;
         unique case (mode_ff)
            tsts_pkg::MODE_TICK: begin
               st_wr = {cnt_ff, tb_ff, last_ff, rdy_ff,
                        retire ? head_nxt : head_ff,
                        retire ? FW'(fill_ff - FW'(1)) : fill_ff};
               q_we = due && !retire;
               q_waddr = {chan_idx, head_ff};
               q_wr = {qnum_ff, qtime_ff,
                       first_fire ? 12'd1 :
                       (qtick_ff < tsts_pkg::TICK_MAX) ? 12'(qtick_ff + 12'd1) : qtick_ff};
            end
            tsts_pkg::MODE_SETT: begin
               st_wr = {32'd0, {1'b0, tval_ff}, last_ff, new_rdy, head_ff, fill_ff};
            end
            tsts_pkg::MODE_ALLOC: begin
               st_wr = {cnt_ff, tb_ff, new_last, rdy_ff, head_ff,
                        ovf ? fill_ff : FW'(fill_ff + FW'(1))};
               q_we = !ovf;
               q_waddr = {chan_idx, tail};
               q_wr = {snum_ff, start_t, 12'd0};
            end
            default: st_wr = {cnt_ff, tb_ff, last_ff, rdy_ff, head_ff, fill_ff};
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR; clr_ff <= '0; rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_CLEAR: begin
               clr_ff <= CW'(clr_ff + CW'(1));
               if (clr_ff == CW'(2**CW - 1)) state_ff <= ST_IDLE;
            end
            ST_IDLE: if (req_tvalid && req_tready) begin
               mode_ff <= req_tuser;
               chan_ff <= req_tdata[1:0];
               hold_ff <= req_tdata[2];
               tval_ff <= req_tdata[65:3];
               snum_ff <= req_tdata[73:66];
               drop_ff <= ({3'b0, req_tdata[1:0]} >= 5'(CHANNELS));
               state_ff <= ST_READ;
            end
            ST_READ: state_ff <= ST_MUL_LO;
            ST_MUL_LO: begin
               {tb_ff, last_ff, rdy_ff, head_ff, fill_ff} <= st_rd[SW-33:0];
               if (mode_ff == tsts_pkg::MODE_TICK && !hold_ff)
                  cnt_ff <= st_rd[SW-1 -: 32] + 32'd1;
               else
                  cnt_ff <= st_rd[SW-1 -: 32];
               state_ff <= ST_MUL_HI;
            end
            ST_MUL_HI: begin
               // head entry arrives the cycle after the state word
               qnum_ff <= q_rd[EW-1 -: 8]; qtime_ff <= q_rd[75:12]; qtick_ff <= q_rd[11:0];
               prod_ff <= mp;
               state_ff <= ST_NOW;
            end
            ST_NOW: begin
               now_ff <= tb_ff + prod_ff;
               state_ff <= ST_FL_LO;
            end
            ST_FL_LO: begin
               flp_ff <= mp;
               state_ff <= ST_FL_HI;
            end
            ST_FL_HI: state_ff <= ST_EVAL;
            // hold here until the output register is free
            ST_EVAL: if (!rsp_valid_ff || rsp_tready) begin
               state_ff <= ST_WRITE;
            end
            ST_WRITE: begin
               res_ff <= res_in;
               state_ff <= ST_OUT;
            end
            ST_OUT: begin
               rsp_valid_ff <= 1'b1;
               state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   `TSTS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata), "result changed while stalled")
   `TSTS_ASSERT_NEXT(a_accept_read, clock, reset, req_tvalid && req_tready,
      state_ff == ST_READ, "accepted item did not start a read")
   `TSTS_ASSERT(a_one_write, clock, reset, !(st_we && state_ff != ST_WRITE &&
      state_ff != ST_CLEAR), "state written outside write step")
   `TSTS_ASSERT(a_write_free, clock, reset, !(state_ff == ST_WRITE && rsp_valid_ff),
      "result loaded over a pending one")
endmodule

[sim/tdma_slot_timing_scheduler_tb.sv]
// Self-checking testbench of the TDMA slot timing scheduler: directed table, then random traffic.
`timescale 1ns / 1ps

module tdma_slot_timing_scheduler_tb;

   localparam int CHANNELS    = 4;
   localparam int QUEUE_DEPTH = 16;
   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int DRAIN_CYCLES = 40;

   typedef struct {
      logic [1:0]  mode;
      logic [1:0]  chan;
      logic        hold;
      logic [62:0] time_value;
      logic [7:0]  slot_number;
   } sched_item_type;

   // one row of the directed table: item, repeat count, optional typed-in result
   typedef struct {
      sched_item_type       item;
      int                   reps;
      bit                   typed;
      tsts_pkg::result_type result;
   } dir_row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [1:0]   req_tuser = '0;
   logic [79:0]  req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [143:0] rsp_tdata;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [2:0]   csr_index = '0;
   logic [29:0]  csr_data = '0;

   tdma_slot_timing_scheduler #(
      .CHANNELS(CHANNELS),
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tuser(req_tuser),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   // Shadow of the block: configuration, channel state, slot queues.
   logic [63:0] burst_ms, period_ns, slot_len_ns, filt_samples, slot_len_samples;
   logic [31:0] samples [CHANNELS];
   logic [63:0] base_ns [CHANNELS];
   logic [63:0] last_start [CHANNELS];
   logic        chan_ready [CHANNELS];
   int          head [CHANNELS];
   int          fill [CHANNELS];
   logic [7:0]  slot_num_q [CHANNELS][QUEUE_DEPTH];
   logic [63:0] slot_time_q [CHANNELS][QUEUE_DEPTH];
   int          slot_ticks_q [CHANNELS][QUEUE_DEPTH];

   tsts_pkg::result_type pending_results [$];
   int          error_count = 0;
   int          items_sent = 0;
   int          cycle_count = 0;
   int          sender_idle_pct = 0;
   int          receiver_idle_pct = 0;
   int          receiver_hold = 0;

   function automatic void reset_shadow();
      burst_ms = 64'd0; period_ns = 64'd41667; slot_len_ns = 64'd30000000;
      filt_samples = 64'd0; slot_len_samples = 64'd720;
      for (int c = 0; c < CHANNELS; c++) begin
         samples[c] = '0; base_ns[c] = '0; last_start[c] = '0;
         chan_ready[c] = 1'b0; head[c] = 0; fill[c] = 0;
      end
   endfunction

   function automatic void apply_reg(logic [2:0] idx, logic [29:0] val);
      case (idx)
         tsts_pkg::REG_BURST: begin
            burst_ms = {54'd0, val[9:0]};
         end
         tsts_pkg::REG_SPER: begin
            period_ns = {44'd0, val[19:0]};
         end
         tsts_pkg::REG_SLEN: begin
            slot_len_ns = {34'd0, val};
         end
         tsts_pkg::REG_FLAT: begin
            filt_samples = {54'd0, val[9:0]};
         end
         tsts_pkg::REG_SSAMP: begin
            slot_len_samples = {51'd0, val[12:0]};
         end
         default: begin
         end
      endcase
   endfunction

   function automatic logic [63:0] channel_now(int c);
      return base_ns[c] + {32'd0, samples[c]} * period_ns;
   endfunction

   // Advance the shadow by one item and return the result it should produce.
   function automatic tsts_pkg::result_type schedule_step(sched_item_type it);
      tsts_pkg::result_type r;
      int          c, h, thr;
      logic [63:0] st, el, last, start;
      r = '0;
      c = int'(it.chan);
      case (it.mode)
         tsts_pkg::MODE_TICK: begin
            if (!it.hold) samples[c] = samples[c] + 32'd1;
            if (fill[c] != 0) begin
               h = head[c];
               st = channel_now(c) - 64'd4 * filt_samples * period_ns;
               if ($signed(st) >= $signed(slot_time_q[c][h])) begin
                  if (slot_ticks_q[c][h] == 0) begin
                     slot_ticks_q[c][h] = 1;
                     r.fired_slot = slot_num_q[c][h];
                  end else begin
                     thr = (slot_len_samples == 0) ? 0 : int'(slot_len_samples) - 1;
                     if (thr > 4095) thr = 4095;
                     if (slot_ticks_q[c][h] >= thr) begin
                        head[c] = (h + 1) % QUEUE_DEPTH;
                        fill[c] = fill[c] - 1;
                     end else if (slot_ticks_q[c][h] < 4095) begin
                        slot_ticks_q[c][h] = slot_ticks_q[c][h] + 1;
                     end
                  end
               end
            end
         end
         tsts_pkg::MODE_SETT: begin
            samples[c] = '0;
            base_ns[c] = {1'b0, it.time_value};
            if ($signed(base_ns[c]) >= $signed(64'd4 * slot_len_ns + 64'd1))
               chan_ready[c] = 1'b1;
         end
         tsts_pkg::MODE_ALLOC: begin
            el = channel_now(c);
            last = last_start[c];
            if ($signed(last) >= $signed(el)) begin
               // a slot still ahead: follow it; channel 0 reports the lead
               if (c == 0) begin
                  r.lead_time = 63'(last - el);
                  r.lead_valid = 1'b1;
               end
               last = last + slot_len_ns;
            end else if (last == 0) begin
               last = el;
            end else if ($signed(el - last) >= $signed(slot_len_ns)) begin
               last = el;   // fell behind by a slot or more: resync
            end else begin
               last = last + slot_len_ns;
            end
            last_start[c] = last;
            start = last + burst_ms * 64'd1000000;
            r.slot_start = 63'(start);
            if (fill[c] >= QUEUE_DEPTH) begin
               r.queue_overflow = 1'b1;
            end else begin
               h = (head[c] + fill[c]) % QUEUE_DEPTH;
               slot_num_q[c][h] = it.slot_number;
               slot_time_q[c][h] = start;
               slot_ticks_q[c][h] = 0;
               fill[c] = fill[c] + 1;
            end
         end
         default: begin
         end
      endcase
      r.initialized = chan_ready[c];
      return r;
   endfunction

   // Offer one item, hold it until taken, record what it should produce.
   task automatic send_item(sched_item_type it, bit typed,
                            tsts_pkg::result_type typed_result);
      tsts_pkg::result_type r;
      tsts_pkg::result_type want;
      if ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= it.mode;
      req_tdata  <= {6'd0, it.slot_number, it.time_value, it.hold, it.chan};
      do @(posedge clock); while (!req_tready);
      r = schedule_step(it);
      want = typed ? typed_result : r;
      pending_results = {pending_results, want};
      items_sent++;
      if (items_sent == 330) begin
         sender_idle_pct = 88; receiver_idle_pct = 27;
      end else if (items_sent == 660) begin
         sender_idle_pct = 0; receiver_idle_pct = 0;
      end else if (items_sent == 720) begin
         receiver_hold = 400;   // long back-pressure stretch
      end
      @(negedge clock);
   endtask

   task automatic send_plain(sched_item_type it);
      send_item(it, 1'b0, '0);
   endtask

   // Drain, let the sequencer settle, then write one register.
   task automatic write_reg(logic [2:0] idx, logic [29:0] val);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      apply_reg(idx, val);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic load_config(int b, int p, int l, int f, int s);
      write_reg(tsts_pkg::REG_BURST, 30'(b));
      write_reg(tsts_pkg::REG_SPER, 30'(p));
      write_reg(tsts_pkg::REG_SLEN, 30'(l));
      write_reg(tsts_pkg::REG_FLAT, 30'(f));
      write_reg(tsts_pkg::REG_SSAMP, 30'(s));
   endtask

   function automatic sched_item_type random_item();
      sched_item_type it;
      it.mode = 2'($urandom_range(3));
      it.chan = 2'($urandom_range(3));
      it.hold = 1'($urandom_range(1));
      it.time_value = {31'($urandom), $urandom};
      it.slot_number = 8'($urandom);
      return it;
   endfunction

   // Well-formed burst on one channel: maybe set time, allocate a few, tick through them.
   task automatic send_sequence();
      sched_item_type it;
      int             c;
      c = int'($urandom_range(CHANNELS - 1));
      it = random_item();
      it.chan = 2'(c);
      it.mode = tsts_pkg::MODE_SETT;
      if ($urandom_range(9) != 0) it.time_value = 63'($urandom_range(0, 5000000));
      if ($urandom_range(3) != 0) send_plain(it);
      repeat ($urandom_range(1, 5)) begin
         it = random_item();
         it.chan = 2'(c);
         it.mode = tsts_pkg::MODE_ALLOC;
         send_plain(it);
      end
      repeat ($urandom_range(4, 30)) begin
         it = random_item();
         it.chan = 2'(c);
         it.mode = tsts_pkg::MODE_TICK;
         it.hold = ($urandom_range(9) == 0);
         send_plain(it);
      end
   endtask

   // Receiver: random stalls, plus one long hold-off counted here.
   always @(negedge clock) begin
      if (receiver_hold > 0) begin
         receiver_hold <= receiver_hold - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   // Compare each accepted result with the oldest outstanding one.
   always @(posedge clock) begin
      tsts_pkg::result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = tsts_pkg::result_type'(rsp_tdata[136:0]);
         if (pending_results.size() == 0) begin
            $error("result with nothing outstanding: %h", rsp_tdata);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (got.fired_slot !== want.fired_slot) begin
               $error("fired_slot expected %0d actual %0d", want.fired_slot, got.fired_slot);
               error_count++;
            end
            if (got.slot_start !== want.slot_start) begin
               $error("slot_start expected %0d actual %0d", want.slot_start, got.slot_start);
               error_count++;
            end
            if (got.lead_time !== want.lead_time) begin
               $error("lead_time expected %0d actual %0d", want.lead_time, got.lead_time);
               error_count++;
            end
            if (got.lead_valid !== want.lead_valid) begin
               $error("lead_valid expected %0d actual %0d", want.lead_valid, got.lead_valid);
               error_count++;
            end
            if (got.initialized !== want.initialized) begin
               $error("initialized expected %0d actual %0d",
                      want.initialized, got.initialized);
               error_count++;
            end
            if (got.queue_overflow !== want.queue_overflow) begin
               $error("queue_overflow expected %0d actual %0d",
                      want.queue_overflow, got.queue_overflow);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   dir_row_type dir_tab [13];

   initial begin
      // tick and unused mode after reset: all zero
      dir_tab[0]  = '{'{tsts_pkg::MODE_TICK, 2'd0, 1'b0, 63'd0, 8'd0}, 1, 1'b1, '0};
      dir_tab[1]  = '{'{MODE_UNUSED, 2'd1, 1'b1, '1, 8'hFF}, 1, 1'b1, '0};
      // largest time base sets the ready flag
      dir_tab[2]  = '{'{tsts_pkg::MODE_SETT, 2'd3, 1'b0, '1, 8'd0}, 1, 1'b1,
                      '{initialized: 1'b1, default: '0}};
      dir_tab[3]  = '{'{tsts_pkg::MODE_TICK, 2'd3, 1'b1, 63'd0, 8'd0}, 1, 1'b1,
                      '{initialized: 1'b1, default: '0}};
      dir_tab[4]  = '{'{tsts_pkg::MODE_SETT, 2'd1, 1'b0, 63'd1000000000, 8'd0}, 1, 1'b0, '0};
      dir_tab[5]  = '{'{tsts_pkg::MODE_ALLOC, 2'd1, 1'b0, 63'd0, 8'hFF}, 1, 1'b0, '0};
      dir_tab[6]  = '{'{tsts_pkg::MODE_ALLOC, 2'd1, 1'b0, 63'd0, 8'h00}, 1, 1'b0, '0};
      dir_tab[7]  = '{'{tsts_pkg::MODE_TICK, 2'd1, 1'b0, 63'd0, 8'd0}, 2, 1'b0, '0};
      dir_tab[8]  = '{'{tsts_pkg::MODE_TICK, 2'd1, 1'b1, 63'd0, 8'd0}, 1, 1'b0, '0};
      // the second channel 0 allocation takes the lead-time path
      dir_tab[9]  = '{'{tsts_pkg::MODE_ALLOC, 2'd0, 1'b0, 63'd0, 8'hA5}, 1, 1'b0, '0};
      dir_tab[10] = '{'{tsts_pkg::MODE_ALLOC, 2'd0, 1'b0, 63'd0, 8'h01}, 1, 1'b0, '0};
      // fill channel 2 past its queue depth
      dir_tab[11] = '{'{tsts_pkg::MODE_ALLOC, 2'd2, 1'b0, 63'd0, 8'h3C}, 17, 1'b0, '0};
      dir_tab[12] = '{'{tsts_pkg::MODE_TICK, 2'd2, 1'b0, 63'd0, 8'd0}, 1, 1'b0, '0};

      reset_shadow();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      sender_idle_pct = 27;
      receiver_idle_pct = 88;
      foreach (dir_tab[i])
         repeat (dir_tab[i].reps) send_item(dir_tab[i].item, dir_tab[i].typed,
                                            dir_tab[i].result);

      // settings from fast firing through extreme register values to random ones
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: load_config(0, 1000, 3000, 0, 3);
            1: load_config(1000, 1000000, 1, 1023, 1);
            2: load_config(0, 1, 1000000000, 0, 4096);
            3: load_config(2, 500, 2000, 2, 2);
            default: load_config($urandom_range(0, 3), $urandom_range(100, 2000),
                                 $urandom_range(1000, 9000), $urandom_range(0, 3),
                                 $urandom_range(1, 6));
         endcase
         while (items_sent < 190 * (ph + 1)) begin
            if ($urandom_range(9) < 8) send_sequence();
            else send_plain(random_item());
         end
      end

      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
